// ===== rtl/pht_pkg.sv =====
`default_nettype none

package pht_pkg;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE       = 3'd0,
    SHAPE_OBROUND      = 3'd1,
    SHAPE_SQUARE       = 3'd2,
    SHAPE_LONG_RECT    = 3'd3,
    SHAPE_OCTAGON      = 3'd4,
    SHAPE_LONG_OCTAGON = 3'd5
  } shape_t;

  typedef enum logic [2:0] {
    REG_PAD_X      = 3'd0,
    REG_PAD_Y      = 3'd1,
    REG_OUTER_SIZE = 3'd2,
    REG_COS_ANGLE  = 3'd3,
    REG_SIN_ANGLE  = 3'd4,
    REG_PAD_SHAPE  = 3'd5
  } reg_index_t;

  // sqrt2 and sqrt2+1, Q2.16
  localparam int KW = 18;
  localparam logic [KW-1:0] SQRT2_Q16   = 18'd92682;
  localparam logic [KW-1:0] SQRT2P1_Q16 = 18'd158218;
  localparam int DIAG_SHIFT = 17;

  localparam int XF_STAGES = 4;

  typedef struct packed {
    logic [XF_STAGES-1:0] stage;
  } occ_t;

endpackage

`default_nettype wire

// ===== rtl/pht_xform.sv =====
`default_nettype none

module pht_xform #(
  parameter int W = 24,
  parameter int F = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] point_x,
  input  logic signed [W-1:0] point_y,
  input  logic signed [W-1:0] pad_x,
  input  logic signed [W-1:0] pad_y,
  input  logic signed [F+1:0] cos_angle,
  input  logic signed [F+1:0] sin_angle,
  input  logic [W-3:0]        outer_size,
  output pht_pkg::occ_t       occ,
  output logic [W+F+3:0]      hx,
  output logic [W+F+3:0]      hy,
  output logic [W+F+5:0]      al,
  output logic [W+F+5:0]      ar,
  output logic [2*W:0]        circ_sum
);

  localparam int TW  = F + 2;
  localparam int SW  = W - 2;
  localparam int DW  = W + 1;
  localparam int PW  = DW + TW;
  localparam int RW  = PW + 1;
  localparam int QW  = RW + 2;
  localparam int SFW = SW + F;
  localparam int CSW = 2 * W + 1;

  logic signed [DW-1:0]  dx, dy;
  logic [DW-1:0]         ndx, ndy;
  logic [W-1:0]          mdx, mdy;
  logic signed [PW-1:0]  pxc, pys, pyc, pxs;
  logic [2*W-1:0]        dxsq, dysq;
  logic signed [RW-1:0]  sx, sy;
  logic [RW-1:0]         nsx, nsy;
  logic [CSW-1:0]        cs3;
  logic signed [QW-1:0]  x2, xp, xm;
  logic [QW-1:0]         sfq, nxp, nxm;
  logic [pht_pkg::XF_STAGES-1:0] v;

  assign ndx = -dx;
  assign ndy = -dy;
  assign mdx = dx[DW-1] ? ndx[W-1:0] : dx[W-1:0];
  assign mdy = dy[DW-1] ? ndy[W-1:0] : dy[W-1:0];

  assign nsx = -sx;
  assign nsy = -sy;
  assign x2  = {sx[RW-1], sx, 1'b0};
  assign sfq = {{(QW - SFW){1'b0}}, outer_size, {F{1'b0}}};
  assign xp  = x2 + sfq;
  assign xm  = x2 - sfq;
  assign nxp = -xp;
  assign nxm = -xm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[pht_pkg::XF_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx       <= {point_x[W-1], point_x} - {pad_x[W-1], pad_x};
      dy       <= {point_y[W-1], point_y} - {pad_y[W-1], pad_y};
      pxc      <= PW'(dx) * PW'(cos_angle);
      pys      <= PW'(dy) * PW'(sin_angle);
      pyc      <= PW'(dy) * PW'(cos_angle);
      pxs      <= PW'(dx) * PW'(sin_angle);
      dxsq     <= (2*W)'(mdx) * (2*W)'(mdx);
      dysq     <= (2*W)'(mdy) * (2*W)'(mdy);
      sx       <= RW'(pxc) + RW'(pys);
      sy       <= RW'(pyc) - RW'(pxs);
      cs3      <= CSW'(dxsq) + CSW'(dysq);
      hx       <= sx[RW-1] ? nsx : sx;
      hy       <= sy[RW-1] ? nsy : sy;
      al       <= xp[QW-1] ? nxp : xp;
      ar       <= xm[QW-1] ? nxm : xm;
      circ_sum <= cs3;
    end
  end

  assign occ.stage = v;

endmodule

`default_nettype wire

// ===== rtl/pht_shape.sv =====
`default_nettype none

module pht_shape #(
  parameter int W = 24,
  parameter int F = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W+F+3:0] hx,
  input  logic [W+F+3:0] hy,
  input  logic [W+F+5:0] al,
  input  logic [W+F+5:0] ar,
  input  logic [2*W:0]   circ_sum,
  input  logic [W-3:0]   outer_size,
  input  logic [2:0]     pad_shape,
  output logic           out_valid,
  output logic           hit
);

  localparam int TW  = F + 2;
  localparam int SW  = W - 2;
  localparam int DW  = W + 1;
  localparam int PW  = DW + TW;
  localparam int RW  = PW + 1;
  localparam int AW  = RW + 1;
  localparam int QW  = RW + 2;
  localparam int BW  = AW + 1;
  localparam int HL  = (QW + 1) / 2;
  localparam int HH  = QW - HL;
  localparam int SQW = 2 * QW;
  localparam int CW  = SQW + 1;
  localparam int SSW = 2 * SW;
  localparam int SKW = SW + pht_pkg::KW;
  localparam int CSW = 2 * W + 1;
  localparam int CCW = CSW + 2;
  localparam int DGA = RW + 1 + pht_pkg::DIAG_SHIFT;
  localparam int DGB = SKW + F;
  localparam int DGW = (DGA > DGB) ? DGA : DGB;

  logic [SSW-1:0]          ssq;
  logic [SKW-1:0]          sk;
  logic [pht_pkg::KW-1:0]  k;
  logic [BW-1:0]           ax, ay, sf, sf2;
  logic [QW-1:0]           sq_op [3];
  logic [2*HH-1:0]         p_hh [3];
  logic [HH+HL-1:0]        p_hl [3];
  logic [2*HL-1:0]         p_ll [3];
  logic [SQW-1:0]          sq [3];
  logic                    f_sq5, f_lr5, f_ob5, f_lb5, f_dg5, f_ci5;
  logic                    f_sq6, f_lr6, f_ob6, f_lb6, f_dg6, f_ci6;
  logic                    v5, v6;
  logic [CW-1:0]           sum_l, sum_r, ssqf;
  logic                    in_l, in_r, hit_next;

  assign k = (pht_pkg::shape_t'(pad_shape) == pht_pkg::SHAPE_LONG_OCTAGON) ?
             pht_pkg::SQRT2P1_Q16 : pht_pkg::SQRT2_Q16;

  // derived from configuration, refreshed every cycle
  always_ff @(posedge clk) begin
    ssq <= SSW'(outer_size) * SSW'(outer_size);
    sk  <= SKW'(outer_size) * SKW'(k);
  end

  assign ax  = BW'({hx, 1'b0});
  assign ay  = BW'({hy, 1'b0});
  assign sf  = BW'({outer_size, {F{1'b0}}});
  assign sf2 = BW'({outer_size, {(F + 1){1'b0}}});

  assign sq_op[0] = al;
  assign sq_op[1] = ar;
  assign sq_op[2] = {1'b0, hy, 1'b0};

  assign sum_l = CW'(sq[0]) + CW'(sq[2]);
  assign sum_r = CW'(sq[1]) + CW'(sq[2]);
  assign ssqf  = CW'(ssq) << (2 * F);
  assign in_l  = sum_l < ssqf;
  assign in_r  = sum_r < ssqf;

  always_comb begin
    unique case (pht_pkg::shape_t'(pad_shape))
      pht_pkg::SHAPE_CIRCLE:       hit_next = f_ci6;
      pht_pkg::SHAPE_OBROUND:      hit_next = in_l || in_r || f_sq6;
      pht_pkg::SHAPE_SQUARE:       hit_next = f_sq6;
      pht_pkg::SHAPE_LONG_RECT:    hit_next = f_lr6;
      pht_pkg::SHAPE_OCTAGON:      hit_next = f_ob6 && f_dg6;
      pht_pkg::SHAPE_LONG_OCTAGON: hit_next = f_lb6 && f_dg6;
      default:                     hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= in_valid;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_sq5 <= (ax < sf) && (ay < sf);
      f_lr5 <= (ax < sf2) && (ay < sf);
      f_ob5 <= !((ax > sf) || (ay > sf));
      f_lb5 <= !((ax > sf2) || (ay > sf));
      f_dg5 <= ((DGW'(hx) + DGW'(hy)) << pht_pkg::DIAG_SHIFT) < (DGW'(sk) << F);
      f_ci5 <= (CCW'(circ_sum) << 2) < CCW'(ssq);
      for (int i = 0; i < 3; i++) begin
        p_hh[i] <= (2*HH)'(sq_op[i][QW-1:HL]) * (2*HH)'(sq_op[i][QW-1:HL]);
        p_hl[i] <= (HH+HL)'(sq_op[i][QW-1:HL]) * (HH+HL)'(sq_op[i][HL-1:0]);
        p_ll[i] <= (2*HL)'(sq_op[i][HL-1:0]) * (2*HL)'(sq_op[i][HL-1:0]);
      end
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SQW'(p_hh[i]) << (2 * HL)) + (SQW'(p_hl[i]) << (HL + 1)) + SQW'(p_ll[i]);
      end
      f_sq6 <= f_sq5;
      f_lr6 <= f_lr5;
      f_ob6 <= f_ob5;
      f_lb6 <= f_lb5;
      f_dg6 <= f_dg5;
      f_ci6 <= f_ci5;
      hit   <= hit_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pad_point_hit_test.sv =====
// Pipeline: hit passes through seven register stages, the first loaded at the
//   edge that takes the request (offset, rotate products, sums, magnitudes,
//   partial squares, squares, compare and select).
// Throughput: one request per cycle; a stalled result freezes the whole pipe.
// Reset: synchronous, clears all valid bits and loads the register defaults.
`default_nettype none

module pad_point_hit_test #(
  parameter int COORD_WIDTH    = 24,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [((COORD_WIDTH > TRIG_FRAC_BITS + 2) ?
                 COORD_WIDTH : TRIG_FRAC_BITS + 2)-1:0] cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = TRIG_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int SW  = W - 2;
  localparam int RW  = W + F + 4;
  localparam int QW  = RW + 2;
  localparam int CSW = 2 * W + 1;

  logic signed [W-1:0]  pad_x, pad_y;
  logic [SW-1:0]        outer_size;
  logic signed [TW-1:0] cos_angle, sin_angle;
  logic [2:0]           pad_shape;
  logic                 en;
  pht_pkg::occ_t        occ;
  logic [RW-1:0]        hx, hy;
  logic [QW-1:0]        al, ar;
  logic [CSW-1:0]       circ_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_x      <= '0;
      pad_y      <= '0;
      outer_size <= '0;
      cos_angle  <= TW'(1) << F;
      sin_angle  <= '0;
      pad_shape  <= '0;
    end else if (cfg_write) begin
      unique case (pht_pkg::reg_index_t'(cfg_index))
        pht_pkg::REG_PAD_X:      pad_x      <= cfg_data[W-1:0];
        pht_pkg::REG_PAD_Y:      pad_y      <= cfg_data[W-1:0];
        pht_pkg::REG_OUTER_SIZE: outer_size <= cfg_data[SW-1:0];
        pht_pkg::REG_COS_ANGLE:  cos_angle  <= cfg_data[TW-1:0];
        pht_pkg::REG_SIN_ANGLE:  sin_angle  <= cfg_data[TW-1:0];
        pht_pkg::REG_PAD_SHAPE:  pad_shape  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pht_xform #(
    .W (W),
    .F (F)
  ) u_xform (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .point_x    (point_x),
    .point_y    (point_y),
    .pad_x      (pad_x),
    .pad_y      (pad_y),
    .cos_angle  (cos_angle),
    .sin_angle  (sin_angle),
    .outer_size (outer_size),
    .occ        (occ),
    .hx         (hx),
    .hy         (hy),
    .al         (al),
    .ar         (ar),
    .circ_sum   (circ_sum)
  );

  pht_shape #(
    .W (W),
    .F (F)
  ) u_shape (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (occ.stage[pht_pkg::XF_STAGES-1]),
    .hx         (hx),
    .hy         (hy),
    .al         (al),
    .ar         (ar),
    .circ_sum   (circ_sum),
    .outer_size (outer_size),
    .pad_shape  (pad_shape),
    .out_valid  (out_valid),
    .hit        (hit)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) rst |=> !out_valid && (occ.stage == '0))
    else $error("pipeline not empty after reset");

  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(occ))
    else $error("front stages moved while output stalled");

  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(en))
    else $error("result appeared while pipe was frozen");
`endif

endmodule

`default_nettype wire

// ===== bench/hit_checker.sv =====
`timescale 1ns / 100ps

module hit_checker
  import pht_pkg::*;
#(
  parameter int COORD_WIDTH    = 24,
  parameter int TRIG_FRAC_BITS = 14,
  parameter int DATA_WIDTH     = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          hit,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [DATA_WIDTH-1:0]         cfg_data,
  output int                            outstanding,
  output int                            mismatches
);

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    bit                            want;
  } probe_t;

  probe_t probes[$];
  probe_t incoming;
  probe_t oldest;

  logic signed [COORD_WIDTH-1:0]    ctr_x;
  logic signed [COORD_WIDTH-1:0]    ctr_y;
  logic [COORD_WIDTH-3:0]           pad_size;
  logic signed [TRIG_FRAC_BITS+1:0] rot_cos;
  logic signed [TRIG_FRAC_BITS+1:0] rot_sin;
  logic [2:0]                       shape_code;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // a^2 + b^2 < c^2, exact
  function automatic bit below_circle(longint a, longint b, longint c);
    logic [127:0] wa, wb, wc;
    wa = 128'(a);
    wb = 128'(b);
    wc = 128'(c);
    return (wa * wa + wb * wb) < (wc * wc);
  endfunction

  // doubled |x|+|y| against r * k, k in Q2.16
  function automatic bit below_diagonal(longint ax, longint ay, longint sz,
                                        logic [KW-1:0] k);
    logic [127:0] lhs, rhs;
    lhs = 128'(ax + ay);
    lhs = lhs << DIAG_SHIFT;
    rhs = 128'(sz);
    rhs = (rhs * k) << TRIG_FRAC_BITS;
    return lhs < rhs;
  endfunction

  function automatic bit pad_contains(logic signed [COORD_WIDTH-1:0] px,
                                      logic signed [COORD_WIDTH-1:0] py);
    longint dx, dy, c, s, x2, y2, ax, ay, sz, sf;
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    c  = longint'(rot_cos);
    s  = longint'(rot_sin);
    x2 = 2 * (dx * c + dy * s);
    y2 = 2 * (dy * c - dx * s);
    ax = magnitude(x2);
    ay = magnitude(y2);
    sz = longint'(pad_size);
    sf = sz << TRIG_FRAC_BITS;
    case (shape_code)
      SHAPE_CIRCLE: begin
        return below_circle(magnitude(2 * dx), magnitude(2 * dy), sz);
      end
      SHAPE_OBROUND: begin
        return below_circle(magnitude(x2 + sf), ay, sf) ||
               below_circle(magnitude(x2 - sf), ay, sf) ||
               (ax < sf && ay < sf);
      end
      SHAPE_SQUARE: begin
        return ax < sf && ay < sf;
      end
      SHAPE_LONG_RECT: begin
        return ax < 2 * sf && ay < sf;
      end
      SHAPE_OCTAGON: begin
        return !(ax > sf || ay > sf) &&
               below_diagonal(ax / 2, ay / 2, sz, SQRT2_Q16);
      end
      SHAPE_LONG_OCTAGON: begin
        return !(ax > 2 * sf || ay > sf) &&
               below_diagonal(ax / 2, ay / 2, sz, SQRT2P1_Q16);
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ctr_x      = '0;
      ctr_y      = '0;
      pad_size   = '0;
      rot_cos    = (TRIG_FRAC_BITS + 2)'(1) << TRIG_FRAC_BITS;
      rot_sin    = '0;
      shape_code = SHAPE_CIRCLE;
      probes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PAD_X:      ctr_x      = cfg_data[COORD_WIDTH-1:0];
          REG_PAD_Y:      ctr_y      = cfg_data[COORD_WIDTH-1:0];
          REG_OUTER_SIZE: pad_size   = cfg_data[COORD_WIDTH-3:0];
          REG_COS_ANGLE:  rot_cos    = cfg_data[TRIG_FRAC_BITS+1:0];
          REG_SIN_ANGLE:  rot_sin    = cfg_data[TRIG_FRAC_BITS+1:0];
          REG_PAD_SHAPE:  shape_code = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        incoming.x    = point_x;
        incoming.y    = point_y;
        incoming.want = pad_contains(point_x, point_y);
        probes.push_back(incoming);
      end
      if (out_valid && !out_stall) begin
        if (probes.size() == 0) begin
          $display("%0t: hit with no request pending: expected none, got %0b",
                   $time, hit);
          mismatches <= mismatches + 1;
        end else begin
          oldest = probes.pop_front();
          if (hit !== oldest.want) begin
            $display("%0t: hit for point (%0d, %0d): expected %0b, got %0b",
                     $time, oldest.x, oldest.y, oldest.want, hit);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= probes.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pht_pkg::*;

  localparam int CW = 24;
  localparam int TF = 14;
  localparam int DW = (CW > TF + 2) ? CW : TF + 2;

  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint SIZE_MAX  = (longint'(1) << (CW - 2)) - 1;
  localparam longint UNITY     = longint'(1) << TF;

  localparam logic [DW-1:0] SIZE_MASK  = DW'((longint'(1) << (CW - 2)) - 1);
  localparam logic [DW-1:0] TRIG_MASK  = DW'((longint'(1) << (TF + 2)) - 1);
  localparam logic [DW-1:0] SHAPE_MASK = DW'(7);

  localparam logic [2:0] SHAPE_UNUSED_A = 3'd6;
  localparam logic [2:0] SHAPE_UNUSED_B = 3'd7;
  localparam logic [2:0] REG_UNUSED_A   = 3'd6;
  localparam logic [2:0] REG_UNUSED_B   = 3'd7;
  localparam int SHAPE_COUNT = 6;

  localparam int IDLE_PCT        = 14;
  localparam int RANDOM_PHASES   = 27;
  localparam int POINTS_PER_PAD  = 50;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] point_x   = '0;
  logic signed [CW-1:0] point_y   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic                 cfg_write = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [DW-1:0]        cfg_data  = '0;

  int     outstanding;
  int     mismatches;
  bit     quiet = 1'b0;
  longint pad_cx, pad_cy, pad_extent;

  pad_point_hit_test #(
    .COORD_WIDTH   (CW),
    .TRIG_FRAC_BITS(TF)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .point_x  (point_x),
    .point_y  (point_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit      (hit),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  hit_checker #(
    .COORD_WIDTH   (CW),
    .TRIG_FRAC_BITS(TF),
    .DATA_WIDTH    (DW)
  ) hit_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic longint random_coord();
    logic signed [CW-1:0] v;
    v = CW'($urandom);
    return v;
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_pad(longint x, longint y, longint size, longint c, longint s,
                          logic [2:0] shape);
    logic [DW-1:0] junk;
    settle();
    junk = ($urandom_range(0, 1) == 0) ? DW'($urandom) : '0;
    write_reg(REG_PAD_X, DW'(x));
    write_reg(REG_PAD_Y, DW'(y));
    write_reg(REG_OUTER_SIZE, (junk & ~SIZE_MASK) | (DW'(size) & SIZE_MASK));
    write_reg(REG_COS_ANGLE, (junk & ~TRIG_MASK) | (DW'(c) & TRIG_MASK));
    write_reg(REG_SIN_ANGLE, (junk & ~TRIG_MASK) | (DW'(s) & TRIG_MASK));
    write_reg(REG_PAD_SHAPE, (junk & ~SHAPE_MASK) | (DW'(shape) & SHAPE_MASK));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, DW'($urandom));
    cfg_write  <= 1'b0;
    pad_cx     = x;
    pad_cy     = y;
    pad_extent = size;
  endtask

  task automatic send_point(longint x, longint y);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= CW'(clamp_coord(x));
    point_y  <= CW'(clamp_coord(y));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic directed_shape(longint x, longint y, longint size, longint c,
                                longint s, logic [2:0] shape,
                                longint far_x, longint far_y);
    load_pad(x, y, size, c, s, shape);
    send_point(x, y);
    send_point(x + size / 2, y);
    send_point(far_x, far_y);
  endtask

  task automatic random_pad();
    longint           x, y, size, c, s;
    logic signed [TF+1:0] tc, ts;
    real              ang;
    int               pick;
    logic [2:0]       shape;
    x = ($urandom_range(0, 3) == 0) ? random_coord() : longint'($urandom_range(0, 20000)) - 10000;
    y = ($urandom_range(0, 3) == 0) ? random_coord() : longint'($urandom_range(0, 20000)) - 10000;
    if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    pick = $urandom_range(0, 9);
    if (pick == 0) size = 0;
    else if (pick == 1) size = SIZE_MAX;
    else if (pick < 6) size = longint'($urandom_range(1, 64));
    else size = longint'($urandom_range(65, 100000));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      tc = (TF + 2)'($urandom);
      ts = (TF + 2)'($urandom);
      c  = tc;
      s  = ts;
    end else if (pick == 1) begin
      case ($urandom_range(0, 3))
        0: begin c = UNITY;  s = 0;      end
        1: begin c = 0;      s = UNITY;  end
        2: begin c = -UNITY; s = 0;      end
        default: begin c = 0; s = -UNITY; end
      endcase
    end else begin
      ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      c   = $rtoi($cos(ang) * UNITY);
      s   = $rtoi($sin(ang) * UNITY);
    end
    pick = $urandom_range(0, 19);
    if (pick < 18) shape = 3'(pick % SHAPE_COUNT);
    else shape = (pick == 18) ? SHAPE_UNUSED_A : SHAPE_UNUSED_B;
    load_pad(x, y, size, c, s, shape);
  endtask

  task automatic aimed_point();
    longint span;
    span = pad_extent + pad_extent / 2 + 2;
    if ($urandom_range(0, 4) == 0)
      send_point(random_coord(), random_coord());
    else
      send_point(pad_cx + longint'($urandom_range(0, 2 * span)) - span,
                 pad_cy + longint'($urandom_range(0, 2 * span)) - span);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: zero-size circle at the origin
    send_point(0, 0);

    directed_shape(0, 0, 100, UNITY, 0, SHAPE_CIRCLE, COORD_MIN, COORD_MAX);
    directed_shape(COORD_MIN, COORD_MAX, SIZE_MAX, 0, UNITY, SHAPE_OBROUND,
                   COORD_MAX, COORD_MIN);
    directed_shape(COORD_MAX, COORD_MIN, SIZE_MAX, -UNITY, 0, SHAPE_SQUARE,
                   COORD_MAX, COORD_MIN + 1000);
    directed_shape(1000, -2000, 3, 11585, 11585, SHAPE_LONG_RECT, COORD_MIN, COORD_MIN);
    directed_shape(0, 0, 200, 11585, -11585, SHAPE_OCTAGON, 70, 70);
    directed_shape(-5, 7, 64, UNITY, 0, SHAPE_LONG_OCTAGON, 59, 7);
    // trig words outside the unit range
    directed_shape(0, 0, 100, 32767, -32768, SHAPE_UNUSED_A, 10, 10);
    directed_shape(0, 0, 0, UNITY, 0, SHAPE_UNUSED_B, COORD_MAX, COORD_MAX);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_pad();
      quiet <= (phase >= 8 && phase < 12);
      for (int i = 0; i < POINTS_PER_PAD; i++) begin
        aimed_point();
        if (phase == 5 && i == POINTS_PER_PAD / 2) settle();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== pad_point_hit_test.f =====
rtl/pht_pkg.sv
rtl/pht_xform.sv
rtl/pht_shape.sv
rtl/pad_point_hit_test.sv
bench/hit_checker.sv
bench/testbench.sv
